/* design/ffp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types, register indexes, opcodes and limits of the frame parser.
// ----------------------------------------------------------------------------
package ffp_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] MAX_PAYLOAD = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_HIGH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEATHER_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_META_LENGTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_LENGTH  = 3'd6;

    localparam logic [BYTE_W-1:0] RST_MAGIC_HIGH     = 8'h55;
    localparam logic [BYTE_W-1:0] RST_MAGIC_LOW      = 8'h00;
    localparam logic [BYTE_W-1:0] RST_FOOTER_HIGH    = 8'h00;
    localparam logic [BYTE_W-1:0] RST_FOOTER_LOW     = 8'h00;
    localparam logic [BYTE_W-1:0] RST_WEATHER_LENGTH = 8'd18;
    localparam logic [BYTE_W-1:0] RST_META_LENGTH    = 8'd216;
    localparam logic [BYTE_W-1:0] RST_STATUS_LENGTH  = 8'd12;

    localparam logic [BYTE_W-1:0] OP_WEATHER = 8'h01;
    localparam logic [BYTE_W-1:0] OP_META    = 8'h02;
    localparam logic [BYTE_W-1:0] OP_STATUS  = 8'h05;
    localparam logic [BYTE_W-1:0] OP_ACK     = 8'hFE;
    localparam logic [BYTE_W-1:0] OP_NAK     = 8'hFF;
    localparam logic [BYTE_W-1:0] ACK_NAK_LENGTH = 8'd1;

    localparam logic KIND_PAYLOAD  = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] magic_high;
        logic [BYTE_W-1:0] magic_low;
        logic [BYTE_W-1:0] footer_high;
        logic [BYTE_W-1:0] footer_low;
        logic [BYTE_W-1:0] weather_length;
        logic [BYTE_W-1:0] meta_length;
        logic [BYTE_W-1:0] status_length;
    } t_cfg;

endpackage

/* design/ffp_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_regs
// Configuration registers of the frame parser, written through a plain port.
// ----------------------------------------------------------------------------
module ffp_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ffp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffp_pkg::BYTE_W-1:0]     i_cfg_data,
    output ffp_pkg::t_cfg                  o_cfg
);
    import ffp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_high     <= RST_MAGIC_HIGH;
            r_cfg.magic_low      <= RST_MAGIC_LOW;
            r_cfg.footer_high    <= RST_FOOTER_HIGH;
            r_cfg.footer_low     <= RST_FOOTER_LOW;
            r_cfg.weather_length <= RST_WEATHER_LENGTH;
            r_cfg.meta_length    <= RST_META_LENGTH;
            r_cfg.status_length  <= RST_STATUS_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAGIC_HIGH:     r_cfg.magic_high     <= i_cfg_data;
                REG_MAGIC_LOW:      r_cfg.magic_low      <= i_cfg_data;
                REG_FOOTER_HIGH:    r_cfg.footer_high    <= i_cfg_data;
                REG_FOOTER_LOW:     r_cfg.footer_low     <= i_cfg_data;
                REG_WEATHER_LENGTH: r_cfg.weather_length <= i_cfg_data;
                REG_META_LENGTH:    r_cfg.meta_length    <= i_cfg_data;
                REG_STATUS_LENGTH:  r_cfg.status_length  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/magic_footer_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_footer_frame_parser
// Byte-stream frame parser with programmable magic, footer and lengths.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid, o_in_stall, i_rx_byte) takes one received
// byte per word. The output channel (o_out_valid, i_out_stall and the result
// fields) gives one word for every payload byte, with its index, and one
// completion word with opcode and length after a valid footer. Bytes of a
// frame that never completes must be dropped by the consumer.
// A byte is taken in every cycle that o_in_stall is low; a payload or
// completion word is registered on acceptance. The rate is set by the single
// framing state register, updated once per byte. While the receiver stalls a
// valid word, the output register holds it and o_in_stall is raised, so no
// byte is taken until the word leaves. Reset returns the registers to their
// defaults, the machine to hunting for the first magic byte, and empties the
// output register. The user writes configuration via i_cfg_we, i_cfg_index
// and i_cfg_data only while the block idles; the block does not enforce it.
// ----------------------------------------------------------------------------
module magic_footer_frame_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ffp_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_kind,
    output logic [ffp_pkg::BYTE_W-1:0]     o_opcode,
    output logic [ffp_pkg::BYTE_W-1:0]     o_byte_index,
    output logic [ffp_pkg::BYTE_W-1:0]     o_payload_byte,
    output logic [ffp_pkg::BYTE_W-1:0]     o_frame_length,
    input  logic                           i_cfg_we,
    input  logic [ffp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffp_pkg::BYTE_W-1:0]     i_cfg_data
);
    import ffp_pkg::*;

    typedef enum logic [2:0] {
        ST_MAGIC_H  = 3'd0,
        ST_MAGIC_L  = 3'd1,
        ST_OPCODE   = 3'd2,
        ST_PAYLOAD  = 3'd3,
        ST_FOOTER_H = 3'd4,
        ST_FOOTER_L = 3'd5
    } t_state;

    t_cfg cfg;

    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_opcode, n_opcode;
    logic [BYTE_W-1:0] r_expected, n_expected;
    logic [BYTE_W-1:0] r_count, n_count;

    logic              r_out_valid;
    logic              r_kind, n_kind;
    logic [BYTE_W-1:0] r_out_opcode;
    logic [BYTE_W-1:0] r_index, n_index;
    logic [BYTE_W-1:0] r_payload, n_payload;
    logic [BYTE_W-1:0] r_flen, n_flen;

    logic              accept;
    logic              n_emit;
    logic              known;
    logic [BYTE_W-1:0] op_len;
    logic [BYTE_W-1:0] sat_len;
    logic [BYTE_W-1:0] count_inc;

    ffp_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign count_inc  = r_count + 8'd1;

    always_comb begin
        known  = 1'b1;
        op_len = '0;
        case (i_rx_byte)
            OP_WEATHER: op_len = cfg.weather_length;
            OP_META:    op_len = cfg.meta_length;
            OP_STATUS:  op_len = cfg.status_length;
            OP_ACK:     op_len = ACK_NAK_LENGTH;
            OP_NAK:     op_len = ACK_NAK_LENGTH;
            default:    known  = 1'b0;
        endcase
        sat_len = (op_len > MAX_PAYLOAD) ? MAX_PAYLOAD : op_len;
    end

    always_comb begin
        n_state    = r_state;
        n_opcode   = r_opcode;
        n_expected = r_expected;
        n_count    = r_count;
        n_emit     = 1'b0;
        n_kind     = KIND_PAYLOAD;
        n_index    = '0;
        n_payload  = '0;
        n_flen     = '0;
        case (r_state)
            ST_MAGIC_L: begin
                if (i_rx_byte == cfg.magic_low) begin
                    n_state = ST_OPCODE;
                end else if (i_rx_byte != cfg.magic_high) begin
                    n_state = ST_MAGIC_H;
                end
            end
            ST_OPCODE: begin
                if (!known) begin
                    n_state = ST_MAGIC_H;
                end else begin
                    n_opcode   = i_rx_byte;
                    n_expected = sat_len;
                    n_count    = '0;
                    n_state    = (sat_len != '0) ? ST_PAYLOAD : ST_FOOTER_H;
                end
            end
            ST_PAYLOAD: begin
                n_emit    = 1'b1;
                n_index   = r_count;
                n_payload = i_rx_byte;
                n_count   = count_inc;
                if (count_inc >= r_expected) begin
                    n_state = ST_FOOTER_H;
                end
            end
            ST_FOOTER_H: begin
                if (i_rx_byte == cfg.footer_high) begin
                    n_state = ST_FOOTER_L;
                end else if (i_rx_byte == cfg.magic_high) begin
                    n_state = ST_MAGIC_L;
                end else begin
                    n_state = ST_MAGIC_H;
                end
            end
            ST_FOOTER_L: begin
                if (i_rx_byte == cfg.footer_low) begin
                    n_emit  = 1'b1;
                    n_kind  = KIND_COMPLETE;
                    n_flen  = r_expected;
                    n_state = ST_MAGIC_H;
                end else if (i_rx_byte == cfg.magic_high) begin
                    n_state = ST_MAGIC_L;
                end else begin
                    n_state = ST_MAGIC_H;
                end
            end
            default: begin
                n_state = (i_rx_byte == cfg.magic_high) ? ST_MAGIC_L : ST_MAGIC_H;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_MAGIC_H;
            r_opcode    <= '0;
            r_expected  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state    <= n_state;
                r_opcode   <= n_opcode;
                r_expected <= n_expected;
                r_count    <= n_count;
            end
            if (accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_kind       <= n_kind;
            r_out_opcode <= r_opcode;
            r_index      <= n_index;
            r_payload    <= n_payload;
            r_flen       <= n_flen;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_opcode       = r_out_opcode;
    assign o_byte_index   = r_index;
    assign o_payload_byte = r_payload;
    assign o_frame_length = r_flen;

endmodule
